### rtl/core/backbone_bend_torsion_angles_assert.svh
// Assertion macros shared by the bend and torsion angle engine.
`ifndef BACKBONE_BEND_TORSION_ANGLES_ASSERT_SVH
`define BACKBONE_BEND_TORSION_ANGLES_ASSERT_SVH
`ifndef SYNTHESIS
`define BBTA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bbta assertion failed");
`define BBTA_NEVER(lbl, clk, rst_n, cond) \
	`BBTA_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define BBTA_ASSERT(lbl, clk, rst_n, prop)
`define BBTA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### rtl/core/bbta_pkg.sv
// Types, widths and constants of the bend and torsion angle engine.
package bbta_pkg;

	localparam int COORD_BITS = 24;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int RED_W = 31;
	localparam int REDUCE_LIM = 30;
	localparam int PROD_W = 2 * RED_W;
	localparam int NORM_W = 64;
	localparam int MAG_W = 64;
	localparam int FIT_W = 16;
	localparam int FIT_HI = 15;
	localparam int FIT_LO = 14;
	localparam int CP_W = 2 * FIT_W + 1;
	localparam int DOT_W = 2 * FIT_W + 2;
	localparam int SQ_W = 64;
	localparam int ROOT_W = SQ_W / 2;
	localparam int ROOT_STEPS = SQ_W / 2;
	localparam int CX_W = 36;
	localparam int ACC_W = 25;
	localparam int STEP_W = 21;
	localparam int CORDIC_STEPS = 20;
	localparam int DEG90_ACC = 2304000;
	localparam int ANGLE_W = 15;
	localparam int ANGLE_MAX = 18000;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [STEP_W-1:0] ATAN_STEP [CORDIC_STEPS] = '{
		21'd1152000, 21'd680065, 21'd359328, 21'd182400, 21'd91554,
		21'd45822, 21'd22916, 21'd11459, 21'd5730, 21'd2865,
		21'd1432, 21'd716, 21'd358, 21'd179, 21'd90,
		21'd45, 21'd22, 21'd11, 21'd6, 21'd3
	};

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [NORM_W-1:0] wide_t;

	typedef struct packed {
		logic   chain_start;
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
	} in_item_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] bend_angle;
		logic [ANGLE_W-1:0] torsion_angle;
		logic               degenerate;
	} out_item_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		diff_t x;
		diff_t y;
		diff_t z;
	} dvec_t;

	typedef struct packed {
		dvec_t ab;
		dvec_t bc;
		dvec_t cd;
	} window_t;

	typedef struct packed {
		wide_t x;
		wide_t y;
		wide_t z;
	} wvec_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [ANGLE_W-1:0] angle;
	} ang_stat_t;

	// b - a, one bit wider than a coordinate
	function automatic dvec_t vec_diff(input point_t a, input point_t b);
		dvec_t d;
		d.x = DIFF_W'(b.x) - DIFF_W'(a.x);
		d.y = DIFF_W'(b.y) - DIFF_W'(a.y);
		d.z = DIFF_W'(b.z) - DIFF_W'(a.z);
		return d;
	endfunction

endpackage

### rtl/core/bbta_angle.sv
// Iterative angle unit: normalise, cross and dot, isqrt, vectoring CORDIC.
module bbta_angle import bbta_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  wvec_t     u,
	input  wvec_t     v,
	output ang_stat_t stat
);

	localparam logic [3:0] A_IDLE  = 4'd0;
	localparam logic [3:0] A_NORM  = 4'd1;
	localparam logic [3:0] A_MUL   = 4'd2;
	localparam logic [3:0] A_CROSS = 4'd3;
	localparam logic [3:0] A_SQ    = 4'd4;
	localparam logic [3:0] A_SUM   = 4'd5;
	localparam logic [3:0] A_ROOT  = 4'd6;
	localparam logic [3:0] A_PREP  = 4'd7;
	localparam logic [3:0] A_ROT   = 4'd8;
	localparam logic [3:0] A_FIN   = 4'd9;

	localparam logic [2:0] N_HOLD = 3'd0;
	localparam logic [2:0] N_R8   = 3'd1;
	localparam logic [2:0] N_R1   = 3'd2;
	localparam logic [2:0] N_L8   = 3'd3;
	localparam logic [2:0] N_L1   = 3'd4;

	function automatic logic [MAG_W-1:0] wabs(input wide_t w);
		return w[NORM_W-1] ? MAG_W'(~w + 1'b1) : MAG_W'(w);
	endfunction

	function automatic logic [2:0] norm_code(input logic [MAG_W-1:0] m);
		logic [2:0] c;
		priority if (m[MAG_W-1:FIT_HI+8] != '0) c = N_R8;
		else if (m[MAG_W-1:FIT_HI] != '0) c = N_R1;
		else if (m == '0) c = N_HOLD;
		else if (m[MAG_W-1:FIT_LO-8] == '0) c = N_L8;
		else if (!m[FIT_LO]) c = N_L1;
		else c = N_HOLD;
		return c;
	endfunction

	function automatic logic [MAG_W-1:0] norm_apply(input logic [MAG_W-1:0] m,
			input logic [2:0] c);
		logic [MAG_W-1:0] r;
		unique case (c)
			N_R8: r = m >> 8;
			N_R1: r = m >> 1;
			N_L8: r = m << 8;
			N_L1: r = m << 1;
			default: r = m;
		endcase
		return r;
	endfunction

	function automatic logic signed [CX_W-1:0] shr_tz(input logic signed [CX_W-1:0] a,
			input logic [4:0] k);
		logic [CX_W-1:0] m;
		logic [CX_W-1:0] s;
		m = a[CX_W-1] ? (~a + 1'b1) : a;
		s = m >> k;
		return a[CX_W-1] ? $signed(~s + 1'b1) : $signed(s);
	endfunction

	logic [3:0] state_q;
	logic       done_q;

	logic [2:0]              us_q, vs_q;
	logic [MAG_W-1:0]        um_q [3];
	logic [MAG_W-1:0]        vm_q [3];
	logic signed [2*FIT_W-1:0] pc_q [6];
	logic signed [2*FIT_W-1:0] pd_q [3];
	logic [CP_W-1:0]         cm_q [3];
	logic signed [DOT_W-1:0] dot_q;
	logic [SQ_W-1:0]         sqp_q [3];
	logic [SQ_W-1:0]         rem_q, root_q, bit_q;
	logic [4:0]              cnt_q;
	logic signed [CX_W-1:0]  x_q, y_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [ANGLE_W-1:0]      angle_q;

	logic [MAG_W-1:0]          ou, ov;
	logic [2:0]                cu, cv;
	logic                      norm_ok;
	logic signed [FIT_W-1:0]   uf [3];
	logic signed [FIT_W-1:0]   vf [3];
	logic signed [CP_W-1:0]    cx [3];
	logic [2*CP_W-1:0]         sqw [3];
	logic [SQ_W-1:0]           trial;
	logic signed [CX_W-1:0]    dx_ext, ry_ext, sx, sy;
	logic signed [ACC_W-1:0]   st;
	logic [ACC_W-1:0]          rsum;
	logic [ACC_W-9:0]          rq;
	logic [ANGLE_W-1:0]        ang_fin;
	logic                      root_last, rot_last;

	always_comb begin
		logic [FIT_W-1:0] t;
		ou = um_q[0] | um_q[1] | um_q[2];
		ov = vm_q[0] | vm_q[1] | vm_q[2];
		cu = norm_code(ou);
		cv = norm_code(ov);
		norm_ok = (cu == N_HOLD) && (cv == N_HOLD);
		for (int k = 0; k < 3; k++) begin
			t = um_q[k][FIT_W-1:0];
			uf[k] = us_q[k] ? $signed(~t + 1'b1) : $signed(t);
			t = vm_q[k][FIT_W-1:0];
			vf[k] = vs_q[k] ? $signed(~t + 1'b1) : $signed(t);
		end
		cx[0] = CP_W'(pc_q[0]) - CP_W'(pc_q[1]);
		cx[1] = CP_W'(pc_q[2]) - CP_W'(pc_q[3]);
		cx[2] = CP_W'(pc_q[4]) - CP_W'(pc_q[5]);
		for (int k = 0; k < 3; k++) begin
			sqw[k] = cm_q[k] * cm_q[k];
		end
		trial = root_q + bit_q;
		dx_ext = CX_W'(dot_q);
		ry_ext = $signed(CX_W'(root_q[ROOT_W-1:0]));
		sx = shr_tz(y_q, cnt_q);
		sy = shr_tz(x_q, cnt_q);
		st = $signed(ACC_W'(ATAN_STEP[cnt_q]));
		rsum = $unsigned(acc_q) + ACC_W'(128);
		rq = rsum[ACC_W-1:8];
		if (acc_q < 0) ang_fin = '0;
		else if (rq > ACC_W'(ANGLE_MAX)) ang_fin = ANGLE_W'(ANGLE_MAX);
		else ang_fin = rq[ANGLE_W-1:0];
		root_last = cnt_q == 5'(ROOT_STEPS - 1);
		rot_last = cnt_q == 5'(CORDIC_STEPS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE:  if (start) state_q <= A_NORM;
				A_NORM:  if (norm_ok) state_q <= A_MUL;
				A_MUL:   state_q <= A_CROSS;
				A_CROSS: state_q <= A_SQ;
				A_SQ:    state_q <= A_SUM;
				A_SUM:   state_q <= A_ROOT;
				A_ROOT:  if (root_last) state_q <= A_PREP;
				A_PREP:  state_q <= A_ROT;
				A_ROT:   if (rot_last) state_q <= A_FIN;
				A_FIN: begin
					state_q <= A_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (start) begin
					us_q <= {u.z[NORM_W-1], u.y[NORM_W-1], u.x[NORM_W-1]};
					vs_q <= {v.z[NORM_W-1], v.y[NORM_W-1], v.x[NORM_W-1]};
					um_q[0] <= wabs(u.x);
					um_q[1] <= wabs(u.y);
					um_q[2] <= wabs(u.z);
					vm_q[0] <= wabs(v.x);
					vm_q[1] <= wabs(v.y);
					vm_q[2] <= wabs(v.z);
				end
			end
			A_NORM: begin
				for (int k = 0; k < 3; k++) begin
					um_q[k] <= norm_apply(um_q[k], cu);
					vm_q[k] <= norm_apply(vm_q[k], cv);
				end
			end
			A_MUL: begin
				pc_q[0] <= uf[1] * vf[2];
				pc_q[1] <= uf[2] * vf[1];
				pc_q[2] <= uf[2] * vf[0];
				pc_q[3] <= uf[0] * vf[2];
				pc_q[4] <= uf[0] * vf[1];
				pc_q[5] <= uf[1] * vf[0];
				for (int k = 0; k < 3; k++) begin
					pd_q[k] <= uf[k] * vf[k];
				end
			end
			A_CROSS: begin
				for (int k = 0; k < 3; k++) begin
					cm_q[k] <= cx[k][CP_W-1] ? (~cx[k] + 1'b1) : cx[k];
				end
				dot_q <= DOT_W'(pd_q[0]) + DOT_W'(pd_q[1]) + DOT_W'(pd_q[2]);
			end
			A_SQ: begin
				for (int k = 0; k < 3; k++) begin
					sqp_q[k] <= sqw[k][SQ_W-1:0];
				end
			end
			A_SUM: begin
				rem_q <= sqp_q[0] + sqp_q[1] + sqp_q[2];
				root_q <= '0;
				bit_q <= SQ_W'(1) << (SQ_W - 2);
				cnt_q <= '0;
			end
			A_ROOT: begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 1'b1;
			end
			A_PREP: begin
				if (dot_q < 0) begin
					x_q <= ry_ext;
					y_q <= -dx_ext;
					acc_q <= ACC_W'(DEG90_ACC);
				end else begin
					x_q <= dx_ext;
					y_q <= ry_ext;
					acc_q <= '0;
				end
				cnt_q <= '0;
			end
			A_ROT: begin
				if (y_q > 0) begin
					x_q <= x_q + sx;
					y_q <= y_q - sy;
					acc_q <= acc_q + st;
				end else begin
					x_q <= x_q - sx;
					y_q <= y_q + sy;
					acc_q <= acc_q - st;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			A_FIN: angle_q <= ang_fin;
			default: ;
		endcase
	end

	assign stat.busy = state_q != A_IDLE;
	assign stat.done = done_q;
	assign stat.angle = angle_q;

endmodule

### rtl/core/bbta_fifo.sv
// Short queue of difference windows between front and back.
module bbta_fifo import bbta_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  window_t wdata,
	output logic    full,
	output logic    valid,
	output window_t rdata,
	input  logic    pop
);

	window_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ptr_inc(wp_q);
			if (pop) rp_q <= ptr_inc(rp_q);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assign full = cnt_q == QCNT_W'(QDEPTH);
	assign valid = cnt_q != '0;
	assign rdata = mem_q[rp_q];

endmodule

### rtl/core/bbta_front.sv
// Front end: point history, chain tracking and difference vectors.
module bbta_front import bbta_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     q_push,
	output window_t  q_wdata
);

	localparam logic [1:0] SEEN_MAX = 2'd3;

	point_t     h0_q, h1_q, h2_q;
	logic [1:0] seen_q;
	point_t     p;
	logic [1:0] seen_eff;
	logic       accept;

	always_comb begin
		p.x = in_data.pos_x;
		p.y = in_data.pos_y;
		p.z = in_data.pos_z;
		seen_eff = in_data.chain_start ? '0 : seen_q;
		accept = in_valid && !q_full;
		q_push = accept && (seen_eff == SEEN_MAX);
		q_wdata.ab = vec_diff(h0_q, h1_q);
		q_wdata.bc = vec_diff(h1_q, h2_q);
		q_wdata.cd = vec_diff(h2_q, p);
	end

	assign in_ready = !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			seen_q <= (seen_eff == SEEN_MAX) ? SEEN_MAX : seen_eff + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h0_q <= h1_q;
			h1_q <= h2_q;
			h2_q <= p;
		end
	end

endmodule

### rtl/core/bbta_back.sv
// Back end: reduction, plane normals, degenerate check, angle units, output register.
`include "backbone_bend_torsion_angles_assert.svh"
module bbta_back import bbta_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  window_t   q_rdata,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RED  = 3'd1;
	localparam logic [2:0] S_MUL1 = 3'd2;
	localparam logic [2:0] S_MUL2 = 3'd3;
	localparam logic [2:0] S_MUL3 = 3'd4;
	localparam logic [2:0] S_CHK  = 3'd5;
	localparam logic [2:0] S_ANG  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	function automatic logic [MAG_W-1:0] dmag(input diff_t d);
		logic [DIFF_W-1:0] m;
		m = d[DIFF_W-1] ? (~d + 1'b1) : d;
		return MAG_W'(m);
	endfunction

	function automatic diff_t dhalf(input diff_t d);
		logic [DIFF_W-1:0] m;
		logic [DIFF_W-1:0] h;
		m = d[DIFF_W-1] ? (~d + 1'b1) : d;
		h = m >> 1;
		return d[DIFF_W-1] ? $signed(~h + 1'b1) : $signed(h);
	endfunction

	logic [2:0] state_q;
	logic       out_valid_q;
	logic       d0_q, d1_q;

	diff_t                    dv_q [3][3];
	logic signed [PROD_W-1:0] pr_q [6];
	wide_t                    n1_q [3];
	wide_t                    n2_q [3];
	out_item_t                res_q, out_data_q;

	logic [2:0]              red_big;
	logic signed [RED_W-1:0] oa [3];
	logic signed [RED_W-1:0] ob [3];
	wide_t                   cx [3];
	logic                    degen, both_done, slot_free, ang_start;
	wvec_t                   bu, bv, tu, tv;
	ang_stat_t               st0, st1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			red_big[i] = 1'b0;
			for (int k = 0; k < 3; k++) begin
				if ((dmag(dv_q[i][k]) >> REDUCE_LIM) != '0) red_big[i] = 1'b1;
			end
		end
		for (int k = 0; k < 3; k++) begin
			oa[k] = RED_W'((state_q == S_MUL2) ? dv_q[1][k] : dv_q[0][k]);
			ob[k] = RED_W'((state_q == S_MUL2) ? dv_q[2][k] : dv_q[1][k]);
		end
		cx[0] = NORM_W'(pr_q[0]) - NORM_W'(pr_q[1]);
		cx[1] = NORM_W'(pr_q[2]) - NORM_W'(pr_q[3]);
		cx[2] = NORM_W'(pr_q[4]) - NORM_W'(pr_q[5]);
		degen = (dv_q[1][0] == '0 && dv_q[1][1] == '0 && dv_q[1][2] == '0)
			|| (dv_q[2][0] == '0 && dv_q[2][1] == '0 && dv_q[2][2] == '0)
			|| (n1_q[0] == '0 && n1_q[1] == '0 && n1_q[2] == '0)
			|| (n2_q[0] == '0 && n2_q[1] == '0 && n2_q[2] == '0);
		bu.x = NORM_W'(dv_q[1][0]);
		bu.y = NORM_W'(dv_q[1][1]);
		bu.z = NORM_W'(dv_q[1][2]);
		bv.x = NORM_W'(dv_q[2][0]);
		bv.y = NORM_W'(dv_q[2][1]);
		bv.z = NORM_W'(dv_q[2][2]);
		tu.x = n1_q[0];
		tu.y = n1_q[1];
		tu.z = n1_q[2];
		tv.x = n2_q[0];
		tv.y = n2_q[1];
		tv.z = n2_q[2];
		both_done = (d0_q || st0.done) && (d1_q || st1.done);
		slot_free = !out_valid_q || out_ready;
		ang_start = (state_q == S_CHK) && !degen;
		q_pop = (state_q == S_IDLE) && q_valid;
	end

	bbta_angle u_bend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ang_start),
		.u      (bu),
		.v      (bv),
		.stat   (st0)
	);

	bbta_angle u_tors (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ang_start),
		.u      (tu),
		.v      (tv),
		.stat   (st1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			d0_q <= 1'b0;
			d1_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (q_valid) state_q <= S_RED;
				S_RED:  if (red_big == '0) state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_MUL3;
				S_MUL3: state_q <= S_CHK;
				S_CHK:  state_q <= degen ? S_DONE : S_ANG;
				S_ANG:  if (both_done) state_q <= S_DONE;
				S_DONE: if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_DONE && slot_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (ang_start) d0_q <= 1'b0;
			else if (st0.done) d0_q <= 1'b1;
			if (ang_start) d1_q <= 1'b0;
			else if (st1.done) d1_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dv_q[0][0] <= q_rdata.ab.x;
			dv_q[0][1] <= q_rdata.ab.y;
			dv_q[0][2] <= q_rdata.ab.z;
			dv_q[1][0] <= q_rdata.bc.x;
			dv_q[1][1] <= q_rdata.bc.y;
			dv_q[1][2] <= q_rdata.bc.z;
			dv_q[2][0] <= q_rdata.cd.x;
			dv_q[2][1] <= q_rdata.cd.y;
			dv_q[2][2] <= q_rdata.cd.z;
		end
		if (state_q == S_RED) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					if (red_big[i]) dv_q[i][k] <= dhalf(dv_q[i][k]);
				end
			end
		end
		if (state_q == S_MUL1 || state_q == S_MUL2) begin
			pr_q[0] <= oa[1] * ob[2];
			pr_q[1] <= oa[2] * ob[1];
			pr_q[2] <= oa[2] * ob[0];
			pr_q[3] <= oa[0] * ob[2];
			pr_q[4] <= oa[0] * ob[1];
			pr_q[5] <= oa[1] * ob[0];
		end
		if (state_q == S_MUL2) n1_q <= cx;
		if (state_q == S_MUL3) n2_q <= cx;
		if (state_q == S_CHK && degen) begin
			res_q.bend_angle <= '0;
			res_q.torsion_angle <= '0;
			res_q.degenerate <= 1'b1;
		end
		if (state_q == S_ANG && both_done) begin
			res_q.bend_angle <= st0.angle;
			res_q.torsion_angle <= ANGLE_W'(ANGLE_MAX) - st1.angle;
			res_q.degenerate <= 1'b0;
		end
		if (state_q == S_DONE && slot_free) out_data_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	`BBTA_ASSERT(a_degen_zero, clk, arst_n, out_valid_q && out_data_q.degenerate |-> out_data_q.bend_angle == '0 && out_data_q.torsion_angle == '0)
	`BBTA_ASSERT(a_angle_range, clk, arst_n, out_valid_q |-> (out_data_q.bend_angle <= ANGLE_W'(ANGLE_MAX)) && (out_data_q.torsion_angle <= ANGLE_W'(ANGLE_MAX)))
	`BBTA_NEVER(a_start_busy, clk, arst_n, ang_start && (st0.busy || st1.busy))
	`BBTA_ASSERT(a_result_src, clk, arst_n, $rose(out_valid_q) |-> $past(state_q) == S_DONE)

endmodule

### rtl/core/backbone_bend_torsion_angles.sv
// Top level of the backbone bend and torsion angle engine.
// Each window is reduced and normalised and then run through a 32-step isqrt and a
// 20-step CORDIC in both angle units; degenerate geometry skips the angle units.
// The back end takes a new window from the queue only once its last result has gone to
// the output register, and points are accepted while the two-entry queue has room.
// Reset: arst_n clears point count, queue pointers, sequencers and output valid at once.
module backbone_bend_torsion_angles import bbta_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	// front to queue
	logic    q_push;
	logic    q_full;
	window_t q_wdata;

	// queue to back
	logic    q_valid;
	logic    q_pop;
	window_t q_rdata;

	// Front: hold the last three points of the chain, drop history on chain start,
	// and form ab, bc and cd once a fourth point arrives.
	bbta_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	// Queue: decouple point intake from the long angle computation.
	bbta_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_rdata),
		.pop    (q_pop)
	);

	// Back: reduce, form normals, check for degenerate geometry, run both angle
	// units side by side and hold the result in the output register.
	bbta_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### verif/backbone_bend_torsion_angles_test.sv
// Testbench for the bend and torsion angle engine: directed and random points, checked in order.
`timescale 1ns / 100ps

module backbone_bend_torsion_angles_test import bbta_pkg::*; ();

	localparam int RANDOM_POINTS = 1500;
	localparam int LONG_HOLD = 600;
	localparam longint CYCLE_LIMIT = 1000000;

	// CORDIC step table, atan(2^-i) in 1/25600 degree
	localparam longint ATAN_TAB [20] = '{
		1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
		5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3
	};

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	backbone_bend_torsion_angles DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// Predictor state: three held points of the current chain
	longint    held_pt [3][3];
	int        held_count;
	in_item_t  pending_points [$];
	out_item_t expected_angles [$];
	int        error_count;
	int        points_sent;
	int        results_seen;
	int        degenerate_seen;
	bit        stimulus_done = 1'b0;
	longint    cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Shift right truncating toward zero
	function automatic longint shr0(longint v, int k);
		return v < 0 ? -((-v) >>> k) : (v >>> k);
	endfunction

	function automatic longint vmax(longint v [3]);
		longint m;
		m = mag(v[0]);
		if (mag(v[1]) > m) m = mag(v[1]);
		if (mag(v[2]) > m) m = mag(v[2]);
		return m;
	endfunction

	function automatic void fit(ref longint v [3], input int hi, input bit grow);
		longint m;
		while (vmax(v) >= (64'sd1 <<< hi))
			for (int j = 0; j < 3; j++) v[j] = shr0(v[j], 1);
		if (grow) begin
			m = vmax(v);
			while (m != 0 && m < (64'sd1 <<< (hi - 1))) begin
				for (int j = 0; j < 3; j++) v[j] = v[j] * 2;
				m = m * 2;
			end
		end
	endfunction

	function automatic void cross3(input longint a [3], input longint b [3],
			output longint c [3]);
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Angle between two nonzero vectors in 0.01 degree
	function automatic longint vector_angle(input longint u0 [3], input longint v0 [3]);
		longint u [3], v [3], c [3];
		longint x, y, acc, t, dx, dy;
		longint unsigned sq;
		u = u0;
		v = v0;
		fit(u, 15, 1'b1);
		fit(v, 15, 1'b1);
		cross3(u, v, c);
		sq = 0;
		for (int j = 0; j < 3; j++) sq += mag(c[j]) * mag(c[j]);
		x = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
		y = longint'(int_sqrt(sq));
		acc = 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			acc = 2304000;
		end
		for (int i = 0; i < 20; i++) begin
			dx = shr0(y, i);
			dy = shr0(x, i);
			if (y > 0) begin
				x += dx; y -= dy; acc += ATAN_TAB[i];
			end else begin
				x -= dx; y += dy; acc -= ATAN_TAB[i];
			end
		end
		if (acc < 0) return 0;
		acc = (acc + 128) >>> 8;
		return acc > ANGLE_MAX ? ANGLE_MAX : acc;
	endfunction

	// Advance the predictor by one accepted point
	function automatic void predict_angles(in_item_t pt);
		longint p [3], ab [3], bc [3], cd [3], n1 [3], n2 [3];
		out_item_t r;
		p[0] = longint'(pt.pos_x);
		p[1] = longint'(pt.pos_y);
		p[2] = longint'(pt.pos_z);
		if (pt.chain_start) held_count = 0;
		if (held_count >= 3) begin
			for (int j = 0; j < 3; j++) begin
				ab[j] = held_pt[1][j] - held_pt[0][j];
				bc[j] = held_pt[2][j] - held_pt[1][j];
				cd[j] = p[j] - held_pt[2][j];
			end
			fit(ab, 30, 1'b0);
			fit(bc, 30, 1'b0);
			fit(cd, 30, 1'b0);
			cross3(ab, bc, n1);
			cross3(bc, cd, n2);
			if (vmax(bc) == 0 || vmax(cd) == 0 || vmax(n1) == 0 || vmax(n2) == 0) begin
				r.bend_angle = '0;
				r.torsion_angle = '0;
				r.degenerate = 1'b1;
			end else begin
				r.bend_angle = ANGLE_W'(vector_angle(bc, cd));
				r.torsion_angle = ANGLE_W'(ANGLE_MAX - vector_angle(n1, n2));
				r.degenerate = 1'b0;
			end
			expected_angles.push_back(r);
		end
		held_pt[0] = held_pt[1];
		held_pt[1] = held_pt[2];
		held_pt[2] = p;
		if (held_count < 3) held_count++;
	endfunction

	function automatic in_item_t make_point(bit start, longint x, longint y, longint z);
		in_item_t pt;
		pt.chain_start = start;
		pt.pos_x = coord_t'(x);
		pt.pos_y = coord_t'(y);
		pt.pos_z = coord_t'(z);
		return pt;
	endfunction

	function automatic longint rand_coord();
		return longint'(coord_t'($urandom));
	endfunction

	// Fill the pending queue: directed chains, then random chains
	initial begin
		longint bx, by, bz, sc;
		int len, kind;
		int queued;
		// Chain across the coordinate extremes
		pending_points.push_back(make_point(1, -8388608, -8388608, -8388608));
		pending_points.push_back(make_point(0, 8388607, 8388607, 8388607));
		pending_points.push_back(make_point(0, -8388608, 8388607, -8388608));
		pending_points.push_back(make_point(0, 8388607, -8388608, 8388607));
		pending_points.push_back(make_point(0, 0, 0, 8388607));
		// Repeated point: zero-length vector
		pending_points.push_back(make_point(0, 0, 0, 8388607));
		// Collinear points: zero normals
		pending_points.push_back(make_point(1, 0, 0, 0));
		pending_points.push_back(make_point(0, 1000, 0, 0));
		pending_points.push_back(make_point(0, 2000, 0, 0));
		pending_points.push_back(make_point(0, 3000, 0, 0));
		// Right angles
		pending_points.push_back(make_point(1, 0, 0, 0));
		pending_points.push_back(make_point(0, 1500, 0, 0));
		pending_points.push_back(make_point(0, 1500, 1500, 0));
		pending_points.push_back(make_point(0, 1500, 1500, 1500));
		pending_points.push_back(make_point(0, 1500, 0, 1500));
		pending_points.push_back(make_point(0, 1501, 0, 0));
		// Short chains: fewer than four points give nothing
		pending_points.push_back(make_point(1, 5, 6, 7));
		pending_points.push_back(make_point(0, 8, 1, 2));
		pending_points.push_back(make_point(1, -1, -2, -3));
		pending_points.push_back(make_point(0, 1, 2, 3));
		pending_points.push_back(make_point(0, 3, 1, 2));
		// Tiny steps
		pending_points.push_back(make_point(0, 3, 2, 2));
		pending_points.push_back(make_point(0, 4, 2, 3));
		queued = pending_points.size();
		while (queued < RANDOM_POINTS + 23) begin
			kind = $urandom_range(0, 9);
			len = (kind == 0) ? $urandom_range(1, 3) : $urandom_range(4, 20);
			bx = rand_coord(); by = rand_coord(); bz = rand_coord();
			// Most chains walk with bond-like steps; some jump anywhere
			sc = (kind < 6) ? 1600 : ((kind < 8) ? 20 : 0);
			for (int k = 0; k < len; k++) begin
				if (sc == 0 || $urandom_range(0, 30) == 0) begin
					bx = rand_coord(); by = rand_coord(); bz = rand_coord();
				end else begin
					bx = longint'(coord_t'(bx + $signed($urandom_range(0, 2 * sc)) - sc));
					by = longint'(coord_t'(by + $signed($urandom_range(0, 2 * sc)) - sc));
					bz = longint'(coord_t'(bz + $signed($urandom_range(0, 2 * sc)) - sc));
				end
				pending_points.push_back(make_point(k == 0 && kind != 9, bx, by, bz));
				queued++;
			end
		end
		stimulus_done = 1'b1;
	end

	// Reset, asserted at start and then released
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: present points from the pending queue with random gaps
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
			points_sent <= 0;
			held_count = 0;
			for (int i = 0; i < 3; i++) held_pt[i] = '{0, 0, 0};
		end else begin
			if (in_valid && in_ready) begin
				predict_angles(in_data);
				points_sent <= points_sent + 1;
			end
			if (in_valid && !in_ready) begin
				// hold until accepted
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_points.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= pending_points.pop_front();
				send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: random stalls plus one long hold-off, compare each transaction
	int  stall_left;
	bit  long_hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			long_hold_done <= 1'b0;
			error_count = 0;
			results_seen = 0;
			degenerate_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_angles.size() == 0) begin
					$display("%0t: unexpected result, actual %p", $realtime, out_data);
					error_count++;
				end else begin
					out_item_t want;
					want = expected_angles.pop_front();
					if (want.degenerate) degenerate_seen++;
					if (want.bend_angle !== out_data.bend_angle)
						$display("%0t: bend_angle expected %0d actual %0d", $realtime,
							want.bend_angle, out_data.bend_angle);
					if (want.torsion_angle !== out_data.torsion_angle)
						$display("%0t: torsion_angle expected %0d actual %0d", $realtime,
							want.torsion_angle, out_data.torsion_angle);
					if (want.degenerate !== out_data.degenerate)
						$display("%0t: degenerate expected %0b actual %0b", $realtime,
							want.degenerate, out_data.degenerate);
					if (want !== out_data) error_count++;
				end
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!long_hold_done && points_sent > 200) begin
				// starve the output so the queue fills and the input stalls
				long_hold_done <= 1'b1;
				out_ready <= 1'b0;
				stall_left <= LONG_HOLD;
			end else if (out_ready && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Cycle counter and run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		wait (stimulus_done && pending_points.size() == 0);
		@(posedge clk);
		while (in_valid || expected_angles.size() > 0) @(posedge clk);
		// Drain: allow for the block's latency to flush any stray result
		repeat (200) @(posedge clk);
		$display("Sent %0d points, checked %0d results (%0d degenerate)",
			points_sent, results_seen, degenerate_seen);
		if (error_count == 0 && expected_angles.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
